// ===== design/vbrhp_pkg.sv =====
`timescale 1ns / 1ps

package vbrhp_pkg;

    // number of table-of-contents bytes in the header
    localparam int unsigned TOC_ENTRIES = 100;

    // widths of the stream fields
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned ACC_W   = 24;

    // record kinds
    localparam logic [KIND_W-1:0] KIND_TAG       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FLAGS     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FRAMES    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BYTES     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TOC       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SCALE     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd6;

    // flag bits that switch on the optional fields
    localparam int unsigned FLAG_FRAMES = 0;
    localparam int unsigned FLAG_BYTES  = 1;
    localparam int unsigned FLAG_TOC    = 2;
    localparam int unsigned FLAG_SCALE  = 3;

    // channel mode code for a single channel
    localparam logic [1:0] CHMODE_MONO = 2'd3;

    // tag offsets
    localparam logic [BYTE_W-1:0] TAG_OFFS_M1_STEREO = 8'd36;
    localparam logic [BYTE_W-1:0] TAG_OFFS_MID       = 8'd21;
    localparam logic [BYTE_W-1:0] TAG_OFFS_M2_MONO   = 8'd13;

    // parse phase
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_HEAD   = 8'b0000_0010,
        PH_TAG    = 8'b0000_0100,
        PH_FLAGS  = 8'b0000_1000,
        PH_FRAMES = 8'b0001_0000,
        PH_BYTES  = 8'b0010_0000,
        PH_TOC    = 8'b0100_0000,
        PH_SCALE  = 8'b1000_0000
    } t_phase;

    // parser state
    typedef struct packed {
        t_phase             phase;
        logic [BYTE_W-1:0]  pos;
        logic               ver;
        logic [1:0]         rate;
        logic [1:0]         chmode;
        logic [3:0]         flags;
        logic [ACC_W-1:0]   acc;
        logic [BYTE_W-1:0]  fstart;
    } t_state;

    // one result record
    typedef struct packed {
        logic                valid;
        logic [KIND_W-1:0]   kind;
        logic [VALUE_W-1:0]  value;
        logic [BYTE_W-1:0]   offset;
        logic [IDX_W-1:0]    toc_idx;
        logic                mpeg1;
        logic                is_end;
    } t_result;

    // expected tag text "Xing"
    function automatic logic [BYTE_W-1:0] tag_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] c;
        unique case (idx)
            2'd0:    c = 8'h58;
            2'd1:    c = 8'h69;
            2'd2:    c = 8'h6E;
            default: c = 8'h67;
        endcase
        return c;
    endfunction

    // offset of the tag from version and channel mode
    function automatic logic [BYTE_W-1:0] tag_offset(input logic ver, input logic [1:0] chmode);
        logic [BYTE_W-1:0] o;
        if (ver) begin
            o = (chmode != CHMODE_MONO) ? TAG_OFFS_M1_STEREO : TAG_OFFS_MID;
        end else begin
            o = (chmode != CHMODE_MONO) ? TAG_OFFS_MID : TAG_OFFS_M2_MONO;
        end
        return o;
    endfunction

    // sample rate, halved for the lower-rate versions
    function automatic logic [VALUE_W-1:0] sample_rate(input logic [1:0] idx, input logic ver);
        logic [16:0] r;
        unique case (idx)
            2'd0:    r = 17'd44100;
            2'd1:    r = 17'd48000;
            2'd2:    r = 17'd32000;
            default: r = 17'd99999;
        endcase
        return ver ? VALUE_W'(r) : VALUE_W'(r >> 1);
    endfunction

    // first enabled optional field after the given phase
    function automatic t_phase next_phase(input t_phase ph, input logic [3:0] flags);
        logic [3:0] later;
        t_phase     nx;
        unique case (ph)
            PH_FLAGS:  later = 4'b1111;
            PH_FRAMES: later = 4'b1110;
            PH_BYTES:  later = 4'b1100;
            PH_TOC:    later = 4'b1000;
            default:   later = 4'b0000;
        endcase
        later = later & flags;
        priority if (later[FLAG_FRAMES]) nx = PH_FRAMES;
        else if (later[FLAG_BYTES])      nx = PH_BYTES;
        else if (later[FLAG_TOC])        nx = PH_TOC;
        else if (later[FLAG_SCALE])      nx = PH_SCALE;
        else                             nx = PH_IDLE;
        return nx;
    endfunction

endpackage

// ===== design/vbrhp_step.sv =====
`timescale 1ns / 1ps

module vbrhp_step (
    input  vbrhp_pkg::t_state           i_state,
    input  logic [vbrhp_pkg::BYTE_W-1:0] i_byte,
    input  logic                        i_start,
    output vbrhp_pkg::t_state           o_state,
    output vbrhp_pkg::t_result          o_res
);
    import vbrhp_pkg::*;

    t_state             st;
    t_state             nst;
    t_result            res;
    logic [BYTE_W-1:0]  k;
    logic [BYTE_W-1:0]  pos_inc;
    logic [VALUE_W-1:0] word;
    logic [3:0]         flags_now;
    logic               toc_last;
    t_phase             nx;

    always_comb begin
        // frame start restarts the parse
        st = i_state;
        if (i_start) begin
            st.phase  = PH_HEAD;
            st.pos    = '0;
            st.flags  = '0;
            st.acc    = '0;
            st.fstart = '0;
        end

        nst       = st;
        res       = '0;
        k         = st.pos - st.fstart;
        pos_inc   = st.pos + 8'd1;
        word      = {st.acc, i_byte};
        flags_now = st.flags;
        toc_last  = ({1'b0, k} + 9'd1) >= 9'(TOC_ENTRIES);
        nx        = PH_IDLE;

        unique case (st.phase)
            PH_IDLE: begin
                // bytes ignored until the next frame start
            end
            PH_HEAD: begin
                if (st.pos == 8'd1) begin
                    nst.ver = i_byte[3];
                end else if (st.pos == 8'd2) begin
                    nst.rate = i_byte[3:2];
                end else if (st.pos == 8'd3) begin
                    nst.chmode = i_byte[7:6];
                end
                if (st.pos >= 8'd3 && pos_inc == tag_offset(nst.ver, nst.chmode)) begin
                    nst.phase  = PH_TAG;
                    nst.fstart = pos_inc;
                end
            end
            PH_TAG: begin
                if (i_byte != tag_char(k[1:0])) begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_NOT_FOUND;
                    res.offset = st.fstart;
                    res.is_end = 1'b1;
                    nst.phase  = PH_IDLE;
                end else if (k == 8'd3) begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_TAG;
                    res.value  = sample_rate(st.rate, st.ver);
                    res.offset = st.fstart;
                    nst.phase  = PH_FLAGS;
                    nst.fstart = pos_inc;
                    nst.acc    = '0;
                end
            end
            PH_FLAGS, PH_FRAMES, PH_BYTES, PH_SCALE: begin
                // big-endian 32-bit word, one byte at a time
                nst.acc = word[ACC_W-1:0];
                if (k == 8'd3) begin
                    if (st.phase == PH_FLAGS) begin
                        flags_now = word[3:0];
                    end
                    nx         = next_phase(st.phase, flags_now);
                    nst.flags  = flags_now;
                    res.valid  = 1'b1;
                    unique case (st.phase)
                        PH_FLAGS:  res.kind = KIND_FLAGS;
                        PH_FRAMES: res.kind = KIND_FRAMES;
                        PH_BYTES:  res.kind = KIND_BYTES;
                        default:   res.kind = KIND_SCALE;
                    endcase
                    res.value  = word;
                    res.offset = st.fstart;
                    res.is_end = (nx == PH_IDLE);
                    nst.phase  = nx;
                    nst.fstart = pos_inc;
                    nst.acc    = '0;
                end
            end
            PH_TOC: begin
                nx          = toc_last ? next_phase(PH_TOC, st.flags) : PH_TOC;
                res.valid   = 1'b1;
                res.kind    = KIND_TOC;
                res.value   = VALUE_W'(i_byte);
                res.offset  = st.pos;
                res.toc_idx = k[IDX_W-1:0];
                res.is_end  = (nx == PH_IDLE);
                if (toc_last) begin
                    nst.phase  = nx;
                    nst.fstart = pos_inc;
                    nst.acc    = '0;
                end
            end
            default: begin
                nst.phase = PH_IDLE;
            end
        endcase

        // byte counter runs while a parse is active
        if (st.phase != PH_IDLE) begin
            nst.pos = pos_inc;
        end
        res.mpeg1 = nst.ver;
    end

    assign o_state = nst;
    assign o_res   = res;

endmodule

// ===== design/vbr_info_header_parser.sv =====
`timescale 1ns / 1ps

// Parses the VBR information header ("Xing" tag) of an MPEG audio frame fed one byte per
// transaction, with tuser set on the first byte of each frame. The
// parse state is updated as the byte is accepted and any record it completes is
// placed in a one-deep output register, so a new byte is accepted every cycle as long as the
// output side keeps taking records (the input waits only while a record is held and not taken).
// A record appears in the cycle after the byte that completes its field. Records carry the tag
// (with the sample rate), the flags word, the frame and byte counts, each table-of-contents
// entry and the VBR scale; a mismatching tag gives a single not-found record. tlast marks the
// record that closes the header; bytes after it are ignored until the next frame start.
module vbr_info_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte[7:0]
    input  logic [0:0]  i_s_axis_tuser,   // frame_start[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // value[31:0], field_offset[39:32],
                                          // toc_index[46:40], mpeg1[47]
    output logic [2:0]  o_m_axis_tuser,   // kind[2:0]
    output logic        o_m_axis_tlast    // is_end
);
    import vbrhp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    t_result r_res;
    logic    r_out_valid;
    logic    accept;

    // next parse state and record for the byte on the input
    vbrhp_step u_step (
        .i_state (r_state),
        .i_byte  (i_s_axis_tdata),
        .i_start (i_s_axis_tuser[0]),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // take a byte whenever the output register is free or being emptied
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // parse state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, pos: '0, ver: 1'b0, rate: '0, chmode: '0,
                         flags: '0, acc: '0, fstart: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= n_res.valid;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept && n_res.valid) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_res.mpeg1, r_res.toc_idx, r_res.offset, r_res.value};
    assign o_m_axis_tuser  = r_res.kind;
    assign o_m_axis_tlast  = r_res.is_end;

endmodule

// ===== design/vbrhp_checker.sv =====
`timescale 1ns / 1ps

module vbrhp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import vbrhp_pkg::*;

    // nothing is shown in the cycle after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("record shown straight after reset");

    // a held record keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("held record changed");

    // entry number only on table-of-contents records
    a_toc_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_TOC |-> o_m_axis_tdata[46:40] == 7'd0)
        else $error("entry number on a non-toc record");

    // a missing tag closes the header with a zero value
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_NOT_FOUND |->
            o_m_axis_tlast && o_m_axis_tdata[31:0] == 32'd0)
        else $error("bad not-found record");

    // a table-of-contents entry stays inside the table
    a_toc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_TOC |->
            o_m_axis_tdata[46:40] < 7'(TOC_ENTRIES) && o_m_axis_tdata[31:8] == 24'd0)
        else $error("toc entry out of range");

endmodule

bind vbr_info_header_parser vbrhp_checker u_vbrhp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
